@@ rtl/core/distance_vector_route_table_unit_defines.svh @@
// Assertion macros for the distance vector route table unit.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_UNIT_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DVRT_ASSERT(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("dvrt: invariant violated");
`define DVRT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dvrt: sequence violated");
`else
`define DVRT_ASSERT(name, cond)
`define DVRT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/core/dvrt_pkg.sv @@
// Shared types and constants of the distance vector route table unit.
`default_nettype none

package dvrt_pkg;

    localparam int NODES       = 16;
    localparam int NODE_W      = $clog2(NODES);
    localparam int ADDR_W      = 2 * NODE_W;
    localparam int ENTRIES     = NODES * NODES;
    localparam int CNT_W       = $clog2(NODES + 1);
    localparam int DIST_W      = 10;
    localparam int OP_W        = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;
    localparam logic [DIST_W-1:0] LIMIT_RESET = 10'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 3'd0,
        OP_LOOKUP    = 3'd1,
        OP_DEL_DST   = 3'd2,
        OP_DEL_ROUTE = 3'd3,
        OP_DEL_NODE  = 3'd4,
        OP_LIST      = 3'd5
    } t_op;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] best_direction;
        logic [DIST_W-1:0] best_distance;
        logic              has_route;
        logic [NODE_W-1:0] listed_destination;
        logic              last;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DIST_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

@@ rtl/core/dvrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/dvrt_ctrl.sv @@
// Operation sequencer: route valid bits, destination flags, RAM access and result issue.
`default_nettype none

module dvrt_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [dvrt_pkg::OP_W-1:0]   i_op,
    input  wire logic [dvrt_pkg::NODE_W-1:0] i_destination,
    input  wire logic [dvrt_pkg::NODE_W-1:0] i_direction,
    input  wire logic [dvrt_pkg::DIST_W-1:0] i_distance,
    input  wire logic [dvrt_pkg::DIST_W-1:0] i_limit,
    output dvrt_pkg::t_mem_req               o_mem,
    input  wire logic [dvrt_pkg::DIST_W-1:0] i_mem_rdata,
    input  wire logic                        i_res_free,
    output logic                             o_res_valid,
    output dvrt_pkg::t_result                o_res
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ADD_RD = 6'b000010,
        S_ADD_WR = 6'b000100,
        S_SCAN   = 6'b001000,
        S_REPORT = 6'b010000,
        S_LIST   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [dvrt_pkg::NODES-1:0]  r_present;
    logic [dvrt_pkg::NODES-1:0]  r_valid [dvrt_pkg::NODES];

    logic [dvrt_pkg::NODE_W-1:0] r_dst;
    logic [dvrt_pkg::NODE_W-1:0] r_dir;
    logic [dvrt_pkg::DIST_W-1:0] r_dist;
    logic                        r_found;
    logic [dvrt_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_scan_pend;
    logic [dvrt_pkg::NODE_W-1:0] r_scan_idx;
    logic [dvrt_pkg::DIST_W-1:0] r_best;
    logic [dvrt_pkg::NODE_W-1:0] r_bdir;
    logic                        r_any;

    logic                        w_accept;
    logic                        w_add_wr;
    logic                        w_cnt_end;
    logic                        w_better;
    logic                        w_above;
    logic [dvrt_pkg::NODE_W-1:0] w_cur;
    logic [dvrt_pkg::NODES-1:0]  w_dir_onehot;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_cur        = r_cnt[dvrt_pkg::NODE_W-1:0];
    assign w_cnt_end    = (r_cnt == dvrt_pkg::CNT_W'(dvrt_pkg::NODES));
    assign w_dir_onehot = dvrt_pkg::NODES'(1) << i_direction;
    assign w_add_wr     = !r_present[r_dst] || !r_valid[r_dst][r_dir] || (r_dist < i_mem_rdata);
    assign w_better     = r_scan_pend && r_valid[r_dst][r_scan_idx] && (i_mem_rdata < r_best);

    // any present destination beyond the one being listed
    always_comb begin
        w_above = 1'b0;
        for (int k = 0; k < dvrt_pkg::NODES; k++) begin
            if (r_present[k] && (dvrt_pkg::NODE_W'(k) > w_cur)) begin
                w_above = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        o_mem       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (dvrt_pkg::t_op'(i_op))
                        dvrt_pkg::OP_ADD:    n_state = S_ADD_RD;
                        dvrt_pkg::OP_LOOKUP: n_state = r_present[i_destination] ? S_SCAN : S_REPORT;
                        dvrt_pkg::OP_LIST:   n_state = (|r_present) ? S_LIST : S_REPORT;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: begin
                o_mem.raddr = {r_dst, r_dir};
                n_state     = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_mem.we    = w_add_wr;
                o_mem.waddr = {r_dst, r_dir};
                o_mem.wdata = r_dist;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                o_mem.raddr = {r_dst, w_cur};
                if (w_cnt_end) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                // not-found lookup and empty listing both give an all-zero result with last set
                o_res_valid          = i_res_free;
                o_res.found          = r_found;
                o_res.best_direction = r_found ? r_bdir : '0;
                o_res.best_distance  = r_found ? r_best : '0;
                o_res.has_route      = r_found && r_any;
                o_res.last           = 1'b1;
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (r_present[w_cur]) begin
                    o_res_valid              = i_res_free;
                    o_res.found              = 1'b1;
                    o_res.listed_destination = w_cur;
                    o_res.last               = !w_above;
                    if (i_res_free && !w_above) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_valid   <= '{default: '0};
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && w_accept) begin
                unique case (dvrt_pkg::t_op'(i_op))
                    dvrt_pkg::OP_DEL_DST: begin
                        r_present[i_destination] <= 1'b0;
                        r_valid[i_destination]   <= '0;
                    end
                    dvrt_pkg::OP_DEL_ROUTE: begin
                        if (r_present[i_destination]) begin
                            r_valid[i_destination][i_direction] <= 1'b0;
                        end
                    end
                    dvrt_pkg::OP_DEL_NODE: begin
                        for (int d = 0; d < dvrt_pkg::NODES; d++) begin
                            if (r_present[d]) begin
                                r_valid[d][i_direction] <= 1'b0;
                                if ((r_valid[d] & ~w_dir_onehot) == '0) begin
                                    r_present[d] <= 1'b0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_ADD_WR && w_add_wr) begin
                if (!r_present[r_dst]) begin
                    r_present[r_dst] <= 1'b1;
                    r_valid[r_dst]   <= dvrt_pkg::NODES'(1) << r_dir;
                end else begin
                    r_valid[r_dst][r_dir] <= 1'b1;
                end
            end
        end
    end

    // payload and scan datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_dst       <= i_destination;
                r_dir       <= i_direction;
                r_dist      <= i_distance;
                r_found     <= (i_op == dvrt_pkg::OP_LOOKUP) && r_present[i_destination];
                r_cnt       <= '0;
                r_scan_pend <= 1'b0;
                r_best      <= i_limit;
                r_bdir      <= '0;
                r_any       <= 1'b0;
            end
            S_SCAN: begin
                r_scan_pend <= !w_cnt_end;
                r_scan_idx  <= w_cur;
                if (!w_cnt_end) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_better) begin
                    r_best <= i_mem_rdata;
                    r_bdir <= r_scan_idx;
                    r_any  <= 1'b1;
                end
            end
            S_LIST: begin
                if (!r_present[w_cur] || i_res_free) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/distance_vector_route_table_unit.sv @@
// Add reads the stored route, then writes it; deletes take effect as accepted; a lookup reads
// the RAM once per neighbour, with one compare stage, then issues its result. Listing gives
// one result per cycle while the output register is free, skipping absent destinations at
// one a cycle. Throughput: one operation at a time; a lookup holds off the input until issue.
// Reset (synchronous, active low) clears the destination flags and all route valid bits
// at once and loads the limit with 1000; no clearing pass is needed.
`default_nettype none
`include "distance_vector_route_table_unit_defines.svh"

module distance_vector_route_table_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // destination[3:0], direction[7:4], distance[17:8], zero fill above
    input  wire logic [dvrt_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // op[2:0]
    input  wire logic [dvrt_pkg::OP_W-1:0]      i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // found[0], best_direction[4:1], best_distance[14:5], has_route[15],
    // listed_destination[19:16], zero fill above
    output logic [dvrt_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dvrt_pkg::DIST_W-1:0]    i_cfg_data
);

    localparam int DST_LO  = 0;
    localparam int DIR_LO  = dvrt_pkg::NODE_W;
    localparam int DIST_LO = 2 * dvrt_pkg::NODE_W;

    logic [dvrt_pkg::DIST_W-1:0] r_limit;
    logic                        r_out_valid;
    dvrt_pkg::t_result           r_out;

    dvrt_pkg::t_mem_req          w_mem;
    logic [dvrt_pkg::DIST_W-1:0] w_mem_rdata;
    logic                        w_res_free;
    logic                        w_res_valid;
    dvrt_pkg::t_result           w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= dvrt_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    dvrt_ram #(
        .WIDTH (dvrt_pkg::DIST_W),
        .DEPTH (dvrt_pkg::ENTRIES)
    ) u_route_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_mem_rdata)
    );

    dvrt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_op          (i_s_axis_tuser),
        .i_destination (i_s_axis_tdata[DST_LO +: dvrt_pkg::NODE_W]),
        .i_direction   (i_s_axis_tdata[DIR_LO +: dvrt_pkg::NODE_W]),
        .i_distance    (i_s_axis_tdata[DIST_LO +: dvrt_pkg::DIST_W]),
        .i_limit       (r_limit),
        .o_mem         (w_mem),
        .i_mem_rdata   (w_mem_rdata),
        .i_res_free    (w_res_free),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // output register: a result waits here while the sequencer moves on
    assign w_res_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = dvrt_pkg::M_TDATA_W'({r_out.listed_destination,
                                                   r_out.has_route,
                                                   r_out.best_distance,
                                                   r_out.best_direction,
                                                   r_out.found});

    `DVRT_ASSERT(a_res_into_free_slot, !w_res_valid || w_res_free)
    `DVRT_ASSERT(a_no_accept_while_issuing, !(w_res_valid && o_s_axis_tready))
    `DVRT_ASSERT(a_no_write_when_idle, !(w_mem.we && o_s_axis_tready))
    `DVRT_ASSERT_NEXT(a_add_write_ends_op, w_mem.we, o_s_axis_tready)

endmodule

`default_nettype wire
